### rtl/segment_tree_point_add_range_sum_macros.svh
// Assertion macros shared by the segment tree sum block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SEGMENT_TREE_POINT_ADD_RANGE_SUM_MACROS_SVH
`define SEGMENT_TREE_POINT_ADD_RANGE_SUM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STPRS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("stprs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STPRS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("stprs assertion failed");

`endif

### rtl/stprs_pkg.sv
// Shared constants, opcodes and types of the segment tree sum block.
// No dependencies; used by every module of the block but stprs_ram.
package stprs_pkg;

    // Tree geometry
    localparam int unsigned LEAVES   = 1024;
    localparam int unsigned TREE_LOG = $clog2(LEAVES);
    localparam int unsigned SPAN     = 1 << TREE_LOG;
    localparam int unsigned DEPTH    = 2 * SPAN;
    localparam int unsigned ADDR_W   = TREE_LOG + 1;
    localparam int unsigned NODE_W   = TREE_LOG + 2;

    // Field widths
    localparam int unsigned OPC_W   = 2;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned END_W   = 11;
    localparam int unsigned SUM_W   = 64;

    // Input tdata layout
    localparam int unsigned OPC_LSB    = 0;
    localparam int unsigned POS_LSB    = OPC_LSB + OPC_W;
    localparam int unsigned VALUE_LSB  = POS_LSB + POS_W;
    localparam int unsigned END_LSB    = VALUE_LSB + VALUE_W;
    localparam int unsigned IN_BITS    = END_LSB + END_W;
    localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Command queue
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;

    typedef logic [OPC_W-1:0] opcode_t;
    localparam opcode_t OP_ADD = 2'd0;
    localparam opcode_t OP_SUM = 2'd1;
    localparam opcode_t OP_SET = 2'd2;

    // Classified command; lo is the leaf node for writes
    typedef struct packed {
        logic                      is_query;
        logic                      overwrite;
        logic [NODE_W-1:0]         lo;
        logic [NODE_W-1:0]         hi;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    // Back end status seen by the front end
    typedef struct packed {
        logic clearing;
        logic pop;
    } back_status_t;

endpackage

### rtl/stprs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module stprs_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/stprs_front.sv
// Front end: accepts input items, classifies them into tree commands and queues them.
// Depends on stprs_pkg and the assertion macro header.
`include "segment_tree_point_add_range_sum_macros.svh"

module stprs_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // fields from bit 0 up: opcode, position, value, range_end, zero pad
    input  logic [stprs_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  stprs_pkg::back_status_t             status,
    output logic                                cmd_valid,
    output stprs_pkg::cmd_t                     cmd
);

    stprs_pkg::cmd_t                     q_reg [stprs_pkg::QDEPTH];
    logic [stprs_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [stprs_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [stprs_pkg::QCNT_W-1:0]        count_reg, count_next;

    stprs_pkg::opcode_t                  opcode;
    logic [stprs_pkg::POS_W-1:0]         position;
    logic signed [stprs_pkg::VALUE_W-1:0] value;
    logic [stprs_pkg::END_W-1:0]         range_end;
    logic [31:0]                         pos_w, end_clamped;
    logic                                accept, keep, push;
    stprs_pkg::cmd_t                     new_cmd;

    // Unpack the item
    assign opcode    = s_tdata[stprs_pkg::OPC_LSB +: stprs_pkg::OPC_W];
    assign position  = s_tdata[stprs_pkg::POS_LSB +: stprs_pkg::POS_W];
    assign value     = s_tdata[stprs_pkg::VALUE_LSB +: stprs_pkg::VALUE_W];
    assign range_end = s_tdata[stprs_pkg::END_LSB +: stprs_pkg::END_W];

    assign pos_w       = 32'(position);
    assign end_clamped = (32'(range_end) > stprs_pkg::LEAVES) ? stprs_pkg::LEAVES
                                                              : 32'(range_end);

    // Classify: drop unknown opcodes and out-of-range writes, map to node indices
    always_comb begin
        keep              = 1'b0;
        new_cmd.is_query  = 1'b0;
        new_cmd.overwrite = 1'b0;
        new_cmd.lo        = stprs_pkg::NODE_W'(pos_w + stprs_pkg::SPAN);
        new_cmd.hi        = stprs_pkg::NODE_W'(end_clamped + stprs_pkg::SPAN);
        new_cmd.value     = value;
        unique case (opcode) inside
            stprs_pkg::OP_ADD, stprs_pkg::OP_SET: begin
                keep              = pos_w < stprs_pkg::LEAVES;
                new_cmd.overwrite = (opcode == stprs_pkg::OP_SET);
            end
            stprs_pkg::OP_SUM: begin
                keep             = 1'b1;
                new_cmd.is_query = 1'b1;
                // empty range: equal bounds end the walk at once
                if (pos_w >= end_clamped) begin
                    new_cmd.lo = '0;
                    new_cmd.hi = '0;
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = (count_reg != stprs_pkg::QCNT_W'(stprs_pkg::QDEPTH)) && !status.clearing;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && keep;

    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Advance queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (status.pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !status.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && status.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the command
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    `STPRS_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, status.pop, count_reg != '0)
    `STPRS_ASSERT_IMP(a_no_accept_clear, aclk, aresetn, status.clearing, !s_tready)
    `STPRS_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1,
                      count_reg <= stprs_pkg::QCNT_W'(stprs_pkg::QDEPTH))

endmodule

### rtl/stprs_back.sv
// Back end: clears the node memory, runs leaf updates and range walks, holds the result.
// Depends on stprs_pkg, stprs_ram and the assertion macro header.
`include "segment_tree_point_add_range_sum_macros.svh"

module stprs_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cmd_valid,
    input  stprs_pkg::cmd_t                cmd,
    output stprs_pkg::back_status_t        status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stprs_pkg::SUM_W-1:0]    m_tdata
);

    localparam logic [2:0] S_CLR     = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_WLEAF   = 3'd2;
    localparam logic [2:0] S_WLEAF_D = 3'd3;
    localparam logic [2:0] S_WUP     = 3'd4;
    localparam logic [2:0] S_QA      = 3'd5;
    localparam logic [2:0] S_QB      = 3'd6;

    logic [2:0]                          state_reg, state_next;
    logic [stprs_pkg::ADDR_W-1:0]        clr_reg, clr_next;
    logic [stprs_pkg::NODE_W-1:0]        lo_reg, lo_next;
    logic [stprs_pkg::NODE_W-1:0]        hi_reg, hi_next;
    logic [stprs_pkg::SUM_W-1:0]         acc_reg, acc_next;
    logic                                pend_reg, pend_next;
    logic                                ow_reg, ow_next;
    logic [stprs_pkg::VALUE_W-1:0]       value_reg, value_next;
    logic                                out_valid_reg, out_valid_next;
    logic [stprs_pkg::SUM_W-1:0]         out_data_reg, out_data_next;

    logic                                we;
    logic [stprs_pkg::ADDR_W-1:0]        waddr, raddr;
    logic [stprs_pkg::SUM_W-1:0]         wdata, rdata;
    logic [stprs_pkg::SUM_W-1:0]         value_ext, acc_plus, leaf_new, up_sum;
    logic [stprs_pkg::NODE_W-1:0]        parent, hi_dec;
    logic                                pop;

    stprs_ram #(
        .WIDTH(stprs_pkg::SUM_W),
        .DEPTH(stprs_pkg::DEPTH)
    ) u_nodes (
        .clk  (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign value_ext = {{(stprs_pkg::SUM_W - stprs_pkg::VALUE_W){value_reg[stprs_pkg::VALUE_W-1]}},
                        value_reg};
    assign acc_plus  = acc_reg + (pend_reg ? rdata : '0);
    assign leaf_new  = ow_reg ? value_ext : rdata + value_ext;
    assign up_sum    = acc_reg + rdata;
    assign parent    = lo_reg >> 1;
    assign hi_dec    = hi_reg - stprs_pkg::NODE_W'(hi_reg[0]);

    // Sequence the node memory
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        ow_next        = ow_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        we             = 1'b0;
        waddr          = lo_reg[stprs_pkg::ADDR_W-1:0];
        wdata          = '0;
        raddr          = lo_reg[stprs_pkg::ADDR_W-1:0];
        pop            = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == stprs_pkg::ADDR_W'(stprs_pkg::DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_valid) begin
                    pop        = 1'b1;
                    lo_next    = cmd.lo;
                    hi_next    = cmd.hi;
                    ow_next    = cmd.overwrite;
                    value_next = cmd.value;
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    state_next = cmd.is_query ? S_QA : S_WLEAF;
                end
            end
            S_WLEAF: begin
                // read the leaf
                state_next = S_WLEAF_D;
            end
            S_WLEAF_D: begin
                // update the leaf, fetch its sibling
                we       = 1'b1;
                wdata    = leaf_new;
                acc_next = leaf_new;
                raddr    = stprs_pkg::ADDR_W'(lo_reg ^ stprs_pkg::NODE_W'(1));
                state_next = (lo_reg == stprs_pkg::NODE_W'(1)) ? S_IDLE : S_WUP;
            end
            S_WUP: begin
                // rebuild the parent, fetch the parent's sibling
                we       = 1'b1;
                waddr    = parent[stprs_pkg::ADDR_W-1:0];
                wdata    = up_sum;
                acc_next = up_sum;
                lo_next  = parent;
                raddr    = stprs_pkg::ADDR_W'(parent ^ stprs_pkg::NODE_W'(1));
                if (parent == stprs_pkg::NODE_W'(1)) begin
                    state_next = S_IDLE;
                end
            end
            S_QA: begin
                // fold in the right-side node, then take the left node if odd
                acc_next  = acc_plus;
                pend_next = 1'b0;
                if (lo_reg >= hi_reg) begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_next = 1'b1;
                        out_data_next  = acc_plus;
                        state_next     = S_IDLE;
                    end
                end else begin
                    pend_next  = lo_reg[0];
                    lo_next    = lo_reg + stprs_pkg::NODE_W'(lo_reg[0]);
                    state_next = S_QB;
                end
            end
            S_QB: begin
                // fold in the left node, take the right node if odd, go up a level
                acc_next   = acc_plus;
                raddr      = stprs_pkg::ADDR_W'(hi_reg - stprs_pkg::NODE_W'(1));
                pend_next  = hi_reg[0];
                lo_next    = lo_reg >> 1;
                hi_next    = hi_dec >> 1;
                state_next = S_QA;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold walk and result payload
    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        acc_reg      <= acc_next;
        pend_reg     <= pend_next;
        ow_reg       <= ow_next;
        value_reg    <= value_next;
        out_data_reg <= out_data_next;
    end

    assign status.clearing = (state_reg == S_CLR);
    assign status.pop      = pop;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

    `STPRS_ASSERT_IMP(a_no_pop_clear, aclk, aresetn, state_reg == S_CLR, !pop)
    `STPRS_ASSERT_IMP(a_we_states, aclk, aresetn, we,
                      state_reg == S_CLR || state_reg == S_WLEAF_D || state_reg == S_WUP)
    `STPRS_ASSERT_IMP(a_walk_order, aclk, aresetn,
                      state_reg == S_QA || state_reg == S_QB, lo_reg <= hi_reg)
    `STPRS_ASSERT_NEXT(a_result_from_walk, aclk, aresetn,
                       !out_valid_reg, !out_valid_reg || $past(state_reg) == S_QA)

endmodule

### rtl/segment_tree_point_add_range_sum.sv
// Top level of the segment tree sum block: front end, command queue and back end.
// Depends on stprs_pkg, stprs_front and stprs_back.
//
// Usage: keeps 1024 signed 64-bit counters as a binary sum tree in one node memory.
// Input channel s_*: one item per handshake carrying opcode, position, value and
// range_end. Add and set update one leaf and return nothing; sum returns one item
// on m_* with the wrapped total over position .. range_end-1 (0 for an empty range).
// Unknown opcodes and writes past the last leaf are dropped.
// Timing: the back end walks the tree one level at a time through a memory with a
// registered read. A write reads the leaf, updates it, then rebuilds each parent up
// to the root; a sum passes through S_QA and S_QB for each tree level visited.
// A two-entry command queue lets new items be taken while a walk is running;
// results leave through an output register.
// Reset: aresetn is synchronous, active low. After reset the block sweeps every node
// of the memory to zero with s_tready held low.
// Stall: when m_tready is low the result waits in the output register; a following
// sum finishes its walk and then holds until the register empties, and the queue
// fills and backpressures s_tready.
module segment_tree_point_add_range_sum (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // fields from bit 0 up: opcode[1:0], position[11:2], value[43:12],
    // range_end[54:44], zero pad[55]
    input  logic [stprs_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // fields from bit 0 up: range_sum[63:0]
    output logic [stprs_pkg::SUM_W-1:0]         m_tdata
);

    stprs_pkg::back_status_t status;
    stprs_pkg::cmd_t         cmd;
    logic                    cmd_valid;

    stprs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .status   (status),
        .cmd_valid(cmd_valid),
        .cmd      (cmd)
    );

    stprs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
